/* sv/u8d_pkg.sv */
`timescale 1ns / 1ps
// u8d_pkg: shared types, constants and the lead byte classifier
// for the utf8 code point decoder; no dependencies

package u8d_pkg;

    localparam int CP_W = 31;

    // substitute character for a broken sequence
    localparam logic [CP_W-1:0] SUBST_CHAR = 31'd63;

    // one result item
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            last_of_run;
    } t_result;

    // classification of a byte seen with no sequence open
    typedef struct packed {
        logic       lead;
        logic [2:0] len;
        logic [4:0] payload;
    } t_lead_info;

    // what one decoded byte yields, handed from decoder to output queue
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    // lead byte: number of continuation bytes and payload bits it carries
    function automatic t_lead_info classify_lead(input logic [7:0] b);
        t_lead_info info;
        info = '0;
        case (b) inside
            8'b110?????: begin
                info.lead    = 1'b1;
                info.len     = 3'd1;
                info.payload = {b[4:0]};
            end
            8'b1110????: begin
                info.lead    = 1'b1;
                info.len     = 3'd2;
                info.payload = {1'b0, b[3:0]};
            end
            8'b11110???: begin
                info.lead    = 1'b1;
                info.len     = 3'd3;
                info.payload = {2'b0, b[2:0]};
            end
            8'b111110??: begin
                info.lead    = 1'b1;
                info.len     = 3'd4;
                info.payload = {3'b0, b[1:0]};
            end
            8'b1111110?: begin
                info.lead    = 1'b1;
                info.len     = 3'd5;
                info.payload = {4'b0, b[0]};
            end
            default: begin
                info = '0;
            end
        endcase
        return info;
    endfunction

endpackage

/* sv/u8d_in_stage.sv */
`timescale 1ns / 1ps
// u8d_in_stage: input register for the byte stream
// depends on nothing but the clock and reset

module u8d_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_load;

    // register frees up when empty or when its byte is decoded this cycle
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

/* sv/u8d_decode.sv */
`timescale 1ns / 1ps
// u8d_decode: sequence state and per-byte result logic
// depends on u8d_pkg

module u8d_decode
    import u8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  logic       i_fire,
    output t_dec_out   o_dec
);

    logic [2:0]      r_remaining;
    logic [2:0]      n_remaining;
    logic [CP_W-1:0] r_partial;
    logic [CP_W-1:0] n_partial;
    logic [CP_W-1:0] w_shifted;
    logic            w_open;
    logic            w_cont;
    t_lead_info      w_info;
    t_result         w_plain;

    assign w_open    = (r_remaining != 3'd0);
    assign w_cont    = (i_byte[7:6] == 2'b10);
    assign w_info    = classify_lead(i_byte);
    assign w_shifted = {r_partial[CP_W-7:0], i_byte[5:0]};

    // the byte passed through unchanged
    always_comb begin
        w_plain.code_point  = {{(CP_W-8){1'b0}}, i_byte};
        w_plain.replaced    = 1'b0;
        w_plain.last_of_run = 1'b1;
    end

    // results and next state for the byte in the input register
    always_comb begin
        o_dec       = '0;
        n_remaining = r_remaining;
        n_partial   = r_partial;
        if (w_open && w_cont) begin
            // continuation: shift six payload bits in
            n_remaining = r_remaining - 3'd1;
            if (r_remaining == 3'd1) begin
                o_dec.count            = 2'd1;
                o_dec.res0.code_point  = w_shifted;
                o_dec.res0.last_of_run = 1'b1;
                n_partial              = '0;
            end else begin
                n_partial = w_shifted;
            end
        end else begin
            // fresh byte, possibly after a broken sequence
            if (w_info.lead) begin
                n_remaining = w_info.len;
                n_partial   = {{(CP_W-5){1'b0}}, w_info.payload};
            end else begin
                n_remaining = 3'd0;
                n_partial   = '0;
            end
            if (w_open) begin
                o_dec.res0.code_point  = SUBST_CHAR;
                o_dec.res0.replaced    = 1'b1;
                o_dec.res0.last_of_run = w_info.lead;
                if (w_info.lead) begin
                    o_dec.count = 2'd1;
                end else begin
                    o_dec.count = 2'd2;
                    o_dec.res1  = w_plain;
                end
            end else if (!w_info.lead) begin
                o_dec.count = 2'd1;
                o_dec.res0  = w_plain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 3'd0;
            r_partial   <= '0;
        end else if (i_fire) begin
            r_remaining <= n_remaining;
            r_partial   <= n_partial;
        end
    end

endmodule

/* sv/u8d_out_queue.sv */
`timescale 1ns / 1ps
// u8d_out_queue: two-slot shifting result queue that drives the output stream
// depends on u8d_pkg

module u8d_out_queue
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dec_out i_push,
    output logic [1:0] o_room,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_head
);

    logic [1:0] r_occ;
    logic [1:0] n_occ;
    t_result    r_slot0;
    t_result    r_slot1;
    t_result    n_slot0;
    t_result    n_slot1;
    t_result    w_base0;
    logic       w_pop;
    logic [1:0] w_left;

    assign w_pop   = (r_occ != 2'd0) && i_ready;
    assign w_left  = r_occ - {1'b0, w_pop};
    assign o_room  = 2'd2 - w_left;
    assign w_base0 = w_pop ? r_slot1 : r_slot0;

    // shift out the head, then append new results behind what is left
    always_comb begin
        n_occ   = w_left + i_push.count;
        n_slot0 = w_base0;
        n_slot1 = r_slot1;
        case (w_left)
            2'd0: begin
                n_slot0 = i_push.res0;
                n_slot1 = i_push.res1;
            end
            2'd1: begin
                n_slot0 = w_base0;
                n_slot1 = i_push.res0;
            end
            default: begin
                n_slot0 = w_base0;
                n_slot1 = r_slot1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_valid = (r_occ != 2'd0);
    assign o_head  = r_slot0;

endmodule

/* sv/utf8_codepoint_decoder.sv */
`timescale 1ns / 1ps
// utf8_codepoint_decoder: top level, byte stream in, code point stream out
// depends on u8d_pkg, u8d_in_stage, u8d_decode, u8d_out_queue

// Decodes original-form UTF-8 (lead bytes with up to five continuation bytes,
// values up to 31 bits) one byte per clock. A byte is taken into an input
// register, decoded combinationally against the sequence state while held, and its
// results go to a two-slot output queue. The first result passes through the
// input register and a queue slot before it is presented on the output.
// With the output always ready the input sustains one byte per cycle. A byte
// that gives two results (a broken sequence followed by a plain byte) always
// comes right after a byte that gave at most one result, so the queue then
// has room for both and the input is never held. Only output stalls hold
// the input.
// tlast marks the final result caused by a byte; tuser flags a '?' that
// replaces a broken sequence. Output ready feeds input ready combinationally.

module utf8_codepoint_decoder
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] code_point, [31] zero
    output logic        m_axis_tuser,   // [0] replaced
    output logic        m_axis_tlast
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_fire;
    logic [1:0] w_room;
    t_dec_out   w_dec;
    t_dec_out   w_push;
    t_result    w_head;

    u8d_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    u8d_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (w_in_byte),
        .i_fire  (w_fire),
        .o_dec   (w_dec)
    );

    // decode the held byte once the queue can take all of its results
    assign w_fire = w_in_valid && (w_dec.count <= w_room);

    always_comb begin
        w_push = w_dec;
        if (!w_fire) begin
            w_push.count = 2'd0;
        end
    end

    u8d_out_queue u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (w_head)
    );

    // output transfer fields
    assign m_axis_tdata = {1'b0, w_head.code_point};
    assign m_axis_tuser = w_head.replaced;
    assign m_axis_tlast = w_head.last_of_run;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for utf8_codepoint_decoder, byte stream in and
// code point stream out, compared against a behavioral decoder kept in step here
// depends on u8d_pkg (result type, code point width, substitute character)

module testbench;
    import u8d_pkg::*;

    localparam int PREDICTED   = -1;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam t_result NO_POINT = '0;

    // one directed row: byte plus typed results, or PREDICTED to use the decoder model
    typedef struct {
        logic [7:0] text_byte;
        int         n_points;
        t_result    p0;
        t_result    p1;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [30:0] code_point, [31] zero
    logic        m_axis_tuser;           // [0] replaced
    logic        m_axis_tlast;

    // decoder model state
    logic [2:0]      seq_left = '0;
    logic [CP_W-1:0] seq_value = '0;

    t_result expected_points[$];
    t_row    directed_rows[$];
    int      mismatch_count = 0;
    int      bytes_sent = 0;
    int      stall_cycles = 0;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;

    utf8_codepoint_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result point(input logic [CP_W-1:0] cp, input logic rep,
                                      input logic last);
        t_result r;
        r.code_point  = cp;
        r.replaced    = rep;
        r.last_of_run = last;
        return r;
    endfunction

    // advance the decoder model by one byte, return the number of code points it gives
    function automatic int decode_text_byte(input logic [7:0] b, output t_result r0,
                                            output t_result r1);
        int n;
        logic opens;
        n = 0;
        r0 = NO_POINT;
        r1 = NO_POINT;
        if (seq_left != 3'd0) begin
            if (b[7:6] == 2'b10) begin
                seq_value = {seq_value[CP_W-7:0], b[5:0]};
                seq_left  = seq_left - 3'd1;
                if (seq_left == 3'd0) begin
                    r0 = point(seq_value, 1'b0, 1'b1);
                    seq_value = '0;
                    return 1;
                end
                return 0;
            end
            // broken sequence, the byte is decoded afresh below
            seq_left  = '0;
            seq_value = '0;
            r0 = point(SUBST_CHAR, 1'b1, 1'b1);
            n = 1;
        end
        opens = 1'b1;
        casez (b)
            8'b110?????: begin seq_value = CP_W'(b[4:0]); seq_left = 3'd1; end
            8'b1110????: begin seq_value = CP_W'(b[3:0]); seq_left = 3'd2; end
            8'b11110???: begin seq_value = CP_W'(b[2:0]); seq_left = 3'd3; end
            8'b111110??: begin seq_value = CP_W'(b[1:0]); seq_left = 3'd4; end
            8'b1111110?: begin seq_value = CP_W'(b[0]);   seq_left = 3'd5; end
            default: opens = 1'b0;
        endcase
        if (!opens) begin
            // plain byte passes through unchanged
            if (n == 1) begin
                r0.last_of_run = 1'b0;
                r1 = point(CP_W'(b), 1'b0, 1'b1);
            end else begin
                r0 = point(CP_W'(b), 1'b0, 1'b1);
            end
            n++;
        end
        return n;
    endfunction

    // drive one byte and wait for its transfer, then queue what it should give
    task automatic transfer_byte(input logic [7:0] b, input int typed_n,
                                 input t_result t0, input t_result t1);
        int n;
        t_result p0;
        t_result p1;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        n = decode_text_byte(b, p0, p1);
        if (typed_n != PREDICTED) begin
            n  = typed_n;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) expected_points.push_back(p0);
        if (n > 1) expected_points.push_back(p1);
        bytes_sent++;
    endtask

    task automatic add_row(input logic [7:0] b, input int n, input t_result r0,
                           input t_result r1);
        t_row row;
        row.text_byte = b;
        row.n_points  = n;
        row.p0        = r0;
        row.p1        = r1;
        directed_rows.push_back(row);
    endtask

    // one random run: mostly well-formed sequences, some cut short, some noise
    task automatic send_random_run();
        int kind;
        int ncont;
        int nsent;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 85) begin
            ncont = $urandom_range(5);
            if (ncont == 0) begin
                case ($urandom_range(3))
                    0, 1: lead = 8'($urandom_range(127));
                    2: lead = {2'b10, 6'($urandom)};
                    default: lead = {7'h7f, 1'($urandom)};
                endcase
                transfer_byte(lead, PREDICTED, NO_POINT, NO_POINT);
            end else begin
                lead = (8'hff << (7 - ncont)) | (8'($urandom) & (8'hff >> (ncont + 2)));
                nsent = (kind < 70) ? ncont : $urandom_range(ncont - 1);
                transfer_byte(lead, PREDICTED, NO_POINT, NO_POINT);
                repeat (nsent) transfer_byte({2'b10, 6'($urandom)}, PREDICTED,
                                             NO_POINT, NO_POINT);
            end
        end else begin
            repeat ($urandom_range(4, 1))
                transfer_byte(8'($urandom), PREDICTED, NO_POINT, NO_POINT);
        end
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result tdata=%h replaced=%b last=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = expected_points.pop_front();
                if (m_axis_tdata !== {1'b0, want.code_point} ||
                    m_axis_tuser !== want.replaced || m_axis_tlast !== want.last_of_run) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: expected cp=%h replaced=%b last=%b,",
                                 want.code_point, want.replaced, want.last_of_run,
                                 " got tdata=%h replaced=%b last=%b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // watchdog
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial begin
        // field extremes and pass-through bytes
        add_row(8'h00, 1, point(31'h0, 1'b0, 1'b1), NO_POINT);
        add_row(8'h7f, 1, point(31'h7f, 1'b0, 1'b1), NO_POINT);
        add_row(8'h80, 1, point(31'h80, 1'b0, 1'b1), NO_POINT);
        add_row(8'hfe, 1, point(31'hfe, 1'b0, 1'b1), NO_POINT);
        add_row(8'hff, 1, point(31'hff, 1'b0, 1'b1), NO_POINT);
        // longest sequence, largest code point
        add_row(8'hfd, 0, NO_POINT, NO_POINT);
        repeat (4) add_row(8'hbf, 0, NO_POINT, NO_POINT);
        add_row(8'hbf, 1, point(31'h7fffffff, 1'b0, 1'b1), NO_POINT);
        // broken sequence then plain byte
        add_row(8'he2, 0, NO_POINT, NO_POINT);
        add_row(8'h82, PREDICTED, NO_POINT, NO_POINT);
        add_row(8'h41, 2, point(SUBST_CHAR, 1'b1, 1'b0), point(31'h41, 1'b0, 1'b1));
        // broken sequence then lead byte, which opens a new sequence
        add_row(8'hf0, 0, NO_POINT, NO_POINT);
        add_row(8'hc3, 1, point(SUBST_CHAR, 1'b1, 1'b1), NO_POINT);
        add_row(8'ha4, PREDICTED, NO_POINT, NO_POINT);
        // four continuation bytes
        add_row(8'hf8, 0, NO_POINT, NO_POINT);
        add_row(8'h88, PREDICTED, NO_POINT, NO_POINT);
        repeat (3) add_row(8'h80, PREDICTED, NO_POINT, NO_POINT);
        // broken sequence then zero byte
        add_row(8'he0, 0, NO_POINT, NO_POINT);
        add_row(8'h00, 2, point(SUBST_CHAR, 1'b1, 1'b0), point(31'h0, 1'b0, 1'b1));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // three idling phases over directed and random bytes
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 81 : 0;
            sink_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 8 : 0;
            if (phase == 0) begin
                foreach (directed_rows[i])
                    transfer_byte(directed_rows[i].text_byte, directed_rows[i].n_points,
                                  directed_rows[i].p0, directed_rows[i].p1);
            end
            while (bytes_sent < (phase + 1) * 340) send_random_run();
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
